// ===== src/lns_pkg.sv =====
// Package for the leaky integrate-and-fire neuron step block.
// Holds the register indexes, configuration type, datapath step codes and FSM states.
// No dependencies.
`default_nettype none

package lns_pkg;

    localparam int DATA_W    = 32;
    localparam int SHORT_W   = 16;
    localparam int CFG_IDX_W = 3;
    localparam int MUL_W     = 33;
    localparam int PROD_W    = 2 * MUL_W;
    localparam int SUM_W     = 49;
    localparam int ACC_W     = 66;
    localparam int NV_W      = 51;

    localparam logic [DATA_W-1:0]  INV_GL_RESET = 32'd65536;
    localparam logic [SHORT_W-1:0] GAIN_RESET   = 16'd655;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_V_THRESHOLD   = 3'd0,
        REG_V_AFTER_SPIKE = 3'd1,
        REG_E_LEAK        = 3'd2,
        REG_INV_GL        = 3'd3,
        REG_STEP_GAIN     = 3'd4,
        REG_REFR_TICKS    = 3'd5,
        REG_V_START       = 3'd6
    } t_reg_idx;

    typedef struct packed {
        logic signed [DATA_W-1:0] v_threshold;
        logic signed [DATA_W-1:0] v_after_spike;
        logic signed [DATA_W-1:0] e_leak;
        logic [DATA_W-1:0]        inv_gl;
        logic [SHORT_W-1:0]       step_gain;
        logic [SHORT_W-1:0]       refr_ticks;
        logic signed [DATA_W-1:0] v_start;
    } t_cfg;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_DRIVE,
        OP_SUM,
        OP_MUL_LO,
        OP_MUL_HI,
        OP_ACC,
        OP_DONE
    } t_op;

    typedef struct packed {
        logic accept;
        t_op  op;
        logic commit;
    } t_dp_cmd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DRIVE,
        ST_SUM,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_ACC,
        ST_DONE
    } t_state;

endpackage

`default_nettype wire

// ===== src/lns_in_if.sv =====
// Input channel of the neuron step block: one word per time tick.
// Depends on lns_pkg for the field widths.
`default_nettype none

interface lns_in_if
    import lns_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] input_current;
    logic                     restart;

    modport source (output valid, output input_current, output restart, input ready);
    modport sink   (input valid, input input_current, input restart, output ready);
endinterface

`default_nettype wire

// ===== src/lns_out_if.sv =====
// Output channel of the neuron step block: one result word per time tick.
// Depends on lns_pkg for the field widths.
`default_nettype none

interface lns_out_if
    import lns_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] potential;
    logic                     spike;

    modport source (output valid, output potential, output spike, input ready);
    modport sink   (input valid, input potential, input spike, output ready);
endinterface

`default_nettype wire

// ===== src/lns_cfg_regs.sv =====
// Configuration register bank of the neuron step block.
// Depends on lns_pkg for the register indexes and the configuration type.
`default_nettype none

module lns_cfg_regs
    import lns_pkg::*;
(
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_cfg_we,
    input  wire [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire [DATA_W-1:0]     i_cfg_data,
    output t_cfg                 o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_V_THRESHOLD:   n_cfg.v_threshold   = $signed(i_cfg_data);
                REG_V_AFTER_SPIKE: n_cfg.v_after_spike = $signed(i_cfg_data);
                REG_E_LEAK:        n_cfg.e_leak        = $signed(i_cfg_data);
                REG_INV_GL:        n_cfg.inv_gl        = i_cfg_data;
                REG_STEP_GAIN:     n_cfg.step_gain     = i_cfg_data[SHORT_W-1:0];
                REG_REFR_TICKS:    n_cfg.refr_ticks    = i_cfg_data[SHORT_W-1:0];
                REG_V_START:       n_cfg.v_start       = $signed(i_cfg_data);
                default:           n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.v_threshold   <= '0;
            r_cfg.v_after_spike <= '0;
            r_cfg.e_leak        <= '0;
            r_cfg.inv_gl        <= INV_GL_RESET;
            r_cfg.step_gain     <= GAIN_RESET;
            r_cfg.refr_ticks    <= '0;
            r_cfg.v_start       <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ===== src/lns_datapath.sv =====
// Datapath of the neuron step block: refractory and spike handling, one shared
// 33x33 signed multiplier, sum, accumulate, saturation and the output word register.
// Depends on lns_pkg; steered by lns_ctrl through t_dp_cmd.
`default_nettype none

module lns_datapath
    import lns_pkg::*;
(
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  t_cfg                     i_cfg,
    input  t_dp_cmd                  i_cmd,
    input  wire signed [DATA_W-1:0]  i_current,
    input  wire                      i_restart,
    output logic signed [DATA_W-1:0] o_potential,
    output logic                     o_spike
);

    logic signed [DATA_W-1:0]  r_mem;
    logic [SHORT_W-1:0]        r_refr;
    logic signed [DATA_W-1:0]  r_v;
    logic                      r_fired;
    logic signed [DATA_W-1:0]  r_cur;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [SUM_W-1:0]   r_sum;
    logic signed [ACC_W-1:0]   r_acc;
    logic signed [DATA_W-1:0]  r_out_pot;
    logic                      r_out_spike;

    logic signed [DATA_W-1:0]  v0;
    logic [SHORT_W-1:0]        rl0;
    logic signed [DATA_W-1:0]  n_v;
    logic [SHORT_W-1:0]        n_refr;
    logic                      n_fired;
    logic signed [MUL_W-1:0]   mul_a;
    logic signed [MUL_W-1:0]   mul_b;
    logic signed [PROD_W-1:0]  mul_p;
    logic signed [SUM_W-1:0]   drive;
    logic signed [NV_W-1:0]    nv;
    logic signed [DATA_W-1:0]  nv_sat;

    // Refractory and threshold handling on the stored potential.
    always_comb begin
        v0      = i_restart ? i_cfg.v_start : r_mem;
        rl0     = i_restart ? '0 : r_refr;
        n_v     = v0;
        n_refr  = rl0;
        n_fired = 1'b0;
        if (rl0 != '0) begin
            n_refr = rl0 - 1'b1;
            n_v    = i_cfg.v_after_spike;
        end else if ($signed(v0) >= $signed(i_cfg.v_threshold)) begin
            n_fired = 1'b1;
            n_v     = i_cfg.v_after_spike;
            n_refr  = i_cfg.refr_ticks;
        end
    end

    // Operands: current by inv_gl, or sum's unsigned low/signed upper part by gain.
    always_comb begin
        case (i_cmd.op)
            OP_DRIVE: begin
                mul_a = {r_cur[DATA_W-1], r_cur};
                mul_b = {1'b0, i_cfg.inv_gl};
            end
            OP_MUL_LO: begin
                mul_a = {1'b0, r_sum[DATA_W-1:0]};
                mul_b = {{(MUL_W-SHORT_W){1'b0}}, i_cfg.step_gain};
            end
            OP_MUL_HI: begin
                mul_a = {{(MUL_W-(SUM_W-DATA_W)){r_sum[SUM_W-1]}}, r_sum[SUM_W-1:DATA_W]};
                mul_b = {{(MUL_W-SHORT_W){1'b0}}, i_cfg.step_gain};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_p = mul_a * mul_b;
    end

    always_comb begin
        drive  = r_prod[SUM_W+15:16];
        nv     = NV_W'(r_v) + NV_W'($signed(r_acc[ACC_W-1:16]));
        nv_sat = nv[DATA_W-1:0];
        if (nv > NV_W'(32'sh7fffffff)) begin
            nv_sat = 32'sh7fffffff;
        end else if (nv < NV_W'(-33'sh080000000)) begin
            nv_sat = 32'sh80000000;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mem  <= '0;
            r_refr <= '0;
        end else begin
            if (i_cmd.accept) begin
                r_refr <= n_refr;
            end
            if (i_cmd.commit) begin
                r_mem <= nv_sat;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_v     <= n_v;
            r_fired <= n_fired;
            r_cur   <= i_current;
        end
        case (i_cmd.op)
            OP_DRIVE:  r_prod <= mul_p;
            OP_SUM:    r_sum  <= SUM_W'(i_cfg.e_leak) - SUM_W'(r_v) + drive;
            OP_MUL_LO: r_prod <= mul_p;
            OP_MUL_HI: begin
                r_prod <= mul_p;
                r_acc  <= r_prod;
            end
            OP_ACC:    r_acc  <= r_acc + $signed({r_prod[2*SHORT_W+1:0], {DATA_W{1'b0}}});
            default:   r_acc  <= r_acc;
        endcase
        if (i_cmd.commit) begin
            r_out_pot   <= r_v;
            r_out_spike <= r_fired;
        end
    end

    assign o_potential = r_out_pot;
    assign o_spike     = r_out_spike;

endmodule

`default_nettype wire

// ===== src/lns_ctrl.sv =====
// Controller of the neuron step block: sequences the datapath steps of one
// tick and owns the input ready and output valid handshakes.
// Depends on lns_pkg for the states and command type.
`default_nettype none

module lns_ctrl
    import lns_pkg::*;
(
    input  wire      i_clk,
    input  wire      i_rst_n,
    input  wire      i_in_valid,
    output logic     o_in_ready,
    output logic     o_out_valid,
    input  wire      i_out_ready,
    output t_dp_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state      = r_state;
        o_in_ready   = 1'b0;
        o_cmd.accept = 1'b0;
        o_cmd.op     = OP_NONE;
        o_cmd.commit = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = ST_DRIVE;
                end
            end
            ST_DRIVE: begin
                o_cmd.op = OP_DRIVE;
                n_state  = ST_SUM;
            end
            ST_SUM: begin
                o_cmd.op = OP_SUM;
                n_state  = ST_MUL_LO;
            end
            ST_MUL_LO: begin
                o_cmd.op = OP_MUL_LO;
                n_state  = ST_MUL_HI;
            end
            ST_MUL_HI: begin
                o_cmd.op = OP_MUL_HI;
                n_state  = ST_ACC;
            end
            ST_ACC: begin
                o_cmd.op = OP_ACC;
                n_state  = ST_DONE;
            end
            ST_DONE: begin
                o_cmd.op = OP_DONE;
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.commit = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        if (o_cmd.commit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_in_ready && i_in_valid) |=> (r_state == ST_DRIVE))
        else $error("accepted word did not start the step sequence");

    a_busy_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !o_in_ready)
        else $error("input ready while a word is in progress");

    a_commit_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |=> (r_out_valid && r_state == ST_IDLE))
        else $error("committed result not presented");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.commit && r_out_valid) |-> i_out_ready)
        else $error("result overwritten before it was taken");

endmodule

`default_nettype wire

// ===== src/lif_neuron_step.sv =====
// Leaky integrate-and-fire neuron, one forward-Euler step per input word.
// The result word is registered in the done step, after the drive, sum, gain and accumulate steps.
// A new word is taken only once the last is committed, after three passes through
// the single shared 33x33 multiplier plus the sum, accumulate and saturate steps.
// Reset (synchronous, active low) clears the potential and refractory counter and
// returns the configuration and controller to reset values; there is no clearing pass.
`default_nettype none

module lif_neuron_step
    import lns_pkg::*;
(
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    lns_in_if.sink               i_in,
    lns_out_if.source            o_out,
    input  wire                  i_cfg_we,
    input  wire [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire [DATA_W-1:0]     i_cfg_data
);

    t_cfg    cfg;
    t_dp_cmd cmd;
    logic    in_ready;
    logic    out_valid;

    lns_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    lns_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .i_out_ready (o_out.ready),
        .o_cmd       (cmd)
    );

    lns_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_cmd       (cmd),
        .i_current   (i_in.input_current),
        .i_restart   (i_in.restart),
        .o_potential (o_out.potential),
        .o_spike     (o_out.spike)
    );

    assign i_in.ready  = in_ready;
    assign o_out.valid = out_valid;

endmodule

`default_nettype wire
